// ===== design/asv_pkg.sv =====
package asv_pkg;

	localparam int DEPTH       = 64;
	localparam int ADDR_W      = 6;
	localparam int CNT_W       = 7;
	localparam int VAL_W       = 64;
	localparam int MAX_LEN_DEF = 64;

	typedef struct packed {
		logic [VAL_W-1:0]  element_value;
		logic [ADDR_W-1:0] swap_target;
		logic              last_element;
	} elem_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             result_last;
		logic             bad_index;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic              ld_we;    // store an incoming element
		logic [ADDR_W-1:0] ld_addr;
		logic              rd_pos;   // read target and word at pos
		logic              chk;      // check target, fetch partner word
		logic              wr1;      // write partner word to pos
		logic              wr2;      // write held word to target
		logic              em_rd;    // read word for emission
		logic              out_load; // move read word into output register
		logic              last;
		logic              clr_bad;
		logic [ADDR_W-1:0] pos;
		logic [CNT_W-1:0]  n;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic swap;
		logic out_free;
	} sts_t;

endpackage

// ===== design/asv_stream_if.sv =====
interface asv_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/apply_swap_sequence_vector_unit.sv =====
// loading takes one element per cycle while elements are offered; the pass visits each position
//   in walk order (one write port on the word store: read, check, and two writes for an interchange)
// emission reads each result from the store, then loads the output register once it is free
// no new element is taken during a vector's pass and emission
// the last result may still wait in the output register while the next vector loads
// reset clears the controller, counters, bad-index flag and reverse_order; stores are not cleared
module apply_swap_sequence_vector_unit #(
	parameter int MAX_LEN = asv_pkg::MAX_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	asv_stream_if.sink   elem,
	asv_stream_if.source result,
	asv_stream_if.sink   cfg
);
	import asv_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	// controller: load counting, pass sequencing (forward or reverse), emission
	// also holds the reverse_order register, written by a cfg transaction
	asv_ctrl #(
		.MAX_LEN(MAX_LEN)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.elem  (elem),
		.cfg   (cfg),
		.sts   (sts),
		.cmd   (cmd)
	);

	// datapath: word and target stores, interchange registers, bad-index flag,
	// and the output register that parts the result side from the load side
	asv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.elem_data(elem.data),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

endmodule

// ===== design/asv_ctrl.sv =====
module asv_ctrl #(
	parameter int MAX_LEN = asv_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	asv_stream_if.sink    elem,
	asv_stream_if.sink    cfg,
	input  asv_pkg::sts_t sts,
	output asv_pkg::cmd_t cmd
);
	import asv_pkg::*;

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_RDT  = 7'b0000010,
		S_RDV  = 7'b0000100,
		S_WR1  = 7'b0001000,
		S_WR2  = 7'b0010000,
		S_EMRD = 7'b0100000,
		S_EMWR = 7'b1000000
	} state_t;

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LEN);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, n_q, k_q;
	logic             rev_cfg_q, rev_q;
	logic             room, last_k, emitting;
	logic [CNT_W-1:0] pos_full;

	assign room     = cnt_q < LIMIT;
	assign last_k   = k_q == (n_q - CNT_W'(1));
	assign emitting = (state_q == S_EMRD) || (state_q == S_EMWR);
	assign pos_full = (rev_q && !emitting) ? (n_q - CNT_W'(1) - k_q) : k_q;

	assign elem.ready = state_q == S_LOAD;
	assign cfg.ready  = 1'b1;

	always_comb begin
		cmd          = '0;
		cmd.ld_we    = (state_q == S_LOAD) && elem.valid && room;
		cmd.ld_addr  = cnt_q[ADDR_W-1:0];
		cmd.rd_pos   = state_q == S_RDT;
		cmd.chk      = state_q == S_RDV;
		cmd.wr1      = state_q == S_WR1;
		cmd.wr2      = state_q == S_WR2;
		cmd.em_rd    = state_q == S_EMRD;
		cmd.out_load = (state_q == S_EMWR) && sts.out_free;
		cmd.last     = last_k;
		cmd.clr_bad  = cmd.out_load && last_k;
		cmd.pos      = pos_full[ADDR_W-1:0];
		cmd.n        = n_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (elem.valid && elem.data.last_element)
					state_d = S_RDT;
			end
			S_RDT: state_d = S_RDV;
			S_RDV: begin
				if (sts.swap)
					state_d = S_WR1;
				else
					state_d = last_k ? S_EMRD : S_RDT;
			end
			S_WR1: state_d = S_WR2;
			S_WR2: state_d = last_k ? S_EMRD : S_RDT;
			S_EMRD: state_d = S_EMWR;
			S_EMWR: begin
				if (sts.out_free)
					state_d = last_k ? S_LOAD : S_EMRD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			n_q       <= '0;
			k_q       <= '0;
			rev_cfg_q <= 1'b0;
			rev_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				rev_cfg_q <= cfg.data;
			unique case (state_q)
				S_LOAD: begin
					if (elem.valid) begin
						if (elem.data.last_element) begin
							n_q   <= cnt_q + CNT_W'(room);
							cnt_q <= '0;
							k_q   <= '0;
							rev_q <= rev_cfg_q;
						end else if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_RDV: begin
					if (!sts.swap)
						k_q <= last_k ? '0 : k_q + CNT_W'(1);
				end
				S_WR2: k_q <= last_k ? '0 : k_q + CNT_W'(1);
				S_EMWR: begin
					if (sts.out_free)
						k_q <= last_k ? '0 : k_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// position counter never passes the vector length
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (k_q < n_q))
		else $error("position counter beyond vector length");

	// a pass always has at least one element
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_RDT) |-> (n_q != '0) && (n_q <= LIMIT))
		else $error("pass started with bad length");

	// load count never exceeds the limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LIMIT)
		else $error("load count beyond limit");

endmodule

// ===== design/asv_dp.sv =====
module asv_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  asv_pkg::elem_t                 elem_data,
	input  asv_pkg::cmd_t                  cmd,
	output asv_pkg::sts_t                  sts,
	asv_stream_if.source                   result
);
	import asv_pkg::*;

	logic [VAL_W-1:0]  val_mem [DEPTH];
	logic [ADDR_W-1:0] tgt_mem [DEPTH];

	logic [VAL_W-1:0]  vrd_q, vpos_q;
	logic [ADDR_W-1:0] trd_q;
	logic              bad_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              in_range;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [VAL_W-1:0]  wdata;

	assign in_range     = {1'b0, trd_q} < cmd.n;
	assign sts.swap     = in_range && (trd_q != cmd.pos);
	assign sts.out_free = !out_valid_q || result.ready;

	// one write and one read port on the word store
	always_comb begin
		we    = cmd.ld_we || cmd.wr1 || cmd.wr2;
		waddr = cmd.ld_we ? cmd.ld_addr : (cmd.wr1 ? cmd.pos : trd_q);
		wdata = cmd.ld_we ? elem_data.element_value : (cmd.wr1 ? vrd_q : vpos_q);
		re    = cmd.rd_pos || cmd.em_rd || (cmd.chk && sts.swap);
		raddr = cmd.chk ? trd_q : cmd.pos;
	end

	always_ff @(posedge clk) begin
		if (we)
			val_mem[waddr] <= wdata;
		if (re)
			vrd_q <= val_mem[raddr];
		if (cmd.ld_we)
			tgt_mem[cmd.ld_addr] <= elem_data.swap_target;
		if (cmd.rd_pos)
			trd_q <= tgt_mem[cmd.pos];
		if (cmd.chk)
			vpos_q <= vrd_q;
		if (cmd.out_load) begin
			res_q.result_value <= vrd_q;
			res_q.result_last  <= cmd.last;
			res_q.bad_index    <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_bad)
				bad_q <= 1'b0;
			else if (cmd.chk && !in_range)
				bad_q <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || result.ready))
		else $error("output register overwritten");

	// second half of an interchange follows the first
	a_swap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr1 |=> cmd.wr2)
		else $error("interchange left half done");

	// pass commands never overlap element loads
	a_no_load_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_we |-> !(cmd.rd_pos || cmd.chk || cmd.wr1 || cmd.wr2 || cmd.em_rd))
		else $error("load during pass");

endmodule

// ===== dv/apply_swap_sequence_vector_unit_tb.sv =====
`timescale 1ns / 1ps

module apply_swap_sequence_vector_unit_tb;

	import asv_pkg::*;

	localparam int MAX_LEN     = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 16;    // idle cycles after the last result before a register write
	localparam int HOLD_CYCLES = 400;   // long output hold-off to back the block up
	localparam int PHASE_ITEMS = 50;
	localparam int SHOW_MAX    = 40;    // mismatch lines printed before going quiet

	typedef enum bit { ROW_ELEM, ROW_CFG } row_kind_t;

	// one line of the directed stimulus table
	typedef struct {
		row_kind_t kind;
		elem_t     e;
		bit        cfg_val;
		bit        pinned;   // single-element vector whose result is typed in
		bit        pin_bad;
	} dir_row_t;

	// per offered element: either a typed-in result or none
	typedef struct {
		bit   pinned;
		res_t res;
	} pin_t;

	logic clk = 1'b0;
	logic arst_n;

	asv_stream_if #(.T(elem_t)) elem_if ();
	asv_stream_if #(.T(res_t))  res_if ();
	asv_stream_if #(.T(logic))  cfg_if ();

	apply_swap_sequence_vector_unit #(
		.MAX_LEN(MAX_LEN)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.elem  (elem_if),
		.result(res_if),
		.cfg   (cfg_if)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor state: its own copy of the stores and the register
	// ---------------------------------------------------------------
	logic [VAL_W-1:0]  word_mem [DEPTH];
	logic [ADDR_W-1:0] tgt_mem  [DEPTH];
	int                fill;
	bit                bad_flag;
	bit                walk_reverse;

	res_t     permuted_q[$];   // results still owed by the block, oldest first
	pin_t     pinned_q[$];     // one entry per offered element, in offer order
	dir_row_t dir_tab[$];

	int errors;
	int vectors_done;
	int elems_sent;
	int results_checked;
	int cycles;
	int idle_pct;
	int stall_pct;
	bit hold_req;

	// load one accepted element; on the mark run the interchange walk
	// and queue one result per stored position
	task automatic permute_accept(input elem_t e, input pin_t pin);
		int n;
		int p;
		int t;
		logic [VAL_W-1:0] tmp;
		res_t r;
		if (fill < MAX_LEN) begin
			word_mem[fill] = e.element_value;
			tgt_mem[fill]  = e.swap_target;
			fill++;
		end
		if (!e.last_element)
			return;
		n = fill;
		for (int k = 0; k < n; k++) begin
			p = walk_reverse ? n - 1 - k : k;
			t = int'(tgt_mem[p]);
			// target not below the loaded count: no exchange, flag the vector
			if (t >= n)
				bad_flag = 1'b1;
			else if (t != p) begin
				tmp         = word_mem[p];
				word_mem[p] = word_mem[t];
				word_mem[t] = tmp;
			end
		end
		if (pin.pinned)
			permuted_q.push_back(pin.res);
		else begin
			for (int k = 0; k < n; k++) begin
				r.result_value = word_mem[k];
				r.result_last  = (k == n - 1);
				r.bad_index    = bad_flag;
				permuted_q.push_back(r);
			end
		end
		fill         = 0;
		bad_flag     = 1'b0;
		vectors_done++;
	endtask

	// input side monitor: register write and element transactions
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
				walk_reverse = cfg_if.data;
			if (elem_if.valid === 1'b1 && elem_if.ready === 1'b1)
				permute_accept(elem_if.data, pinned_q.pop_front());
		end
	end

	// output side monitor: every result transaction against the oldest expectation
	always @(posedge clk) begin
		res_t exp_r;
		res_t got;
		bit   bad;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got = res_if.data;
			if (permuted_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("%0t: unexpected result value %h last %b bad_index %b",
						$time, got.result_value, got.result_last, got.bad_index);
			end else begin
				exp_r = permuted_q.pop_front();
				bad   = 1'b0;
				if (got.result_value !== exp_r.result_value) begin
					bad = 1'b1;
					if (errors < SHOW_MAX)
						$display("%0t: result_value expected %h got %h",
							$time, exp_r.result_value, got.result_value);
				end
				if (got.result_last !== exp_r.result_last) begin
					bad = 1'b1;
					if (errors < SHOW_MAX)
						$display("%0t: result_last expected %b got %b",
							$time, exp_r.result_last, got.result_last);
				end
				if (got.bad_index !== exp_r.bad_index) begin
					bad = 1'b1;
					if (errors < SHOW_MAX)
						$display("%0t: bad_index expected %b got %b",
							$time, exp_r.bad_index, got.bad_index);
				end
				if (bad)
					errors++;
				results_checked++;
			end
		end
	end

	// receiver: random stalls, or a long counted hold-off when asked for
	always @(posedge clk) begin
		int hold_left;
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else
			res_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, permuted_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one element, with a random gap in front, and wait for the transaction
	task automatic offer(input elem_t e, input bit pinned, input bit pin_bad);
		pin_t pin;
		pin.pinned             = pinned;
		pin.res.result_value   = e.element_value;
		pin.res.result_last    = 1'b1;
		pin.res.bad_index      = pin_bad;
		pinned_q.push_back(pin);
		while ($urandom_range(99) < idle_pct) begin
			elem_if.valid <= 1'b0;
			@(posedge clk);
		end
		elem_if.valid <= 1'b1;
		elem_if.data  <= e;
		@(posedge clk);
		while (elem_if.ready !== 1'b1)
			@(posedge clk);
		elem_nums_bump();
	endtask

	function automatic void elem_nums_bump();
		elems_sent++;
	endfunction

	// wait until the block owes nothing, then let it settle
	task automatic drain();
		elem_if.valid <= 1'b0;
		// let the monitor queue the results of the last transaction first
		@(posedge clk);
		while (permuted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input bit v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// one random vector of len elements; most keep targets in range
	task automatic send_vector(input int len);
		int   m;
		bit   wild;
		elem_t e;
		m    = (len > MAX_LEN) ? MAX_LEN : len;
		wild = ($urandom_range(99) < 20);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0:       e.element_value = '0;
				1:       e.element_value = '1;
				default: e.element_value = {$urandom, $urandom};
			endcase
			if (wild)
				e.swap_target = ADDR_W'($urandom_range(DEPTH - 1));
			else if (i < m && $urandom_range(9) == 0)
				e.swap_target = ADDR_W'(i);
			else
				e.swap_target = ADDR_W'($urandom_range(m - 1));
			e.last_element = (i == len - 1);
			offer(e, 1'b0, 1'b0);
		end
	endtask

	task automatic tab_add(input row_kind_t kind, input logic [VAL_W-1:0] v,
		input logic [ADDR_W-1:0] t, input bit lst, input bit pinned, input bit pin_bad);
		dir_row_t r;
		r.kind             = kind;
		r.cfg_val          = v[0];
		r.e.element_value  = v;
		r.e.swap_target    = t;
		r.e.last_element   = lst;
		r.pinned           = pinned;
		r.pin_bad          = pin_bad;
		dir_tab.push_back(r);
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int len;
		int pick;
		int goal;

		// every input known from time zero
		arst_n        = 1'b0;
		elem_if.valid = 1'b0;
		elem_if.data  = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = 1'b0;
		res_if.ready  = 1'b0;
		hold_req      = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		fill          = 0;
		bad_flag      = 1'b0;
		walk_reverse  = 1'b0;

		// directed table; single-element vectors carry their typed-in result
		tab_add(ROW_CFG,  64'd0, 6'd0, 1'b0, 1'b0, 1'b0);
		// extremes of the word and target, single-element vectors
		tab_add(ROW_ELEM, 64'd0, 6'd0, 1'b1, 1'b1, 1'b0);
		tab_add(ROW_ELEM, '1, 6'd63, 1'b1, 1'b1, 1'b1);
		tab_add(ROW_ELEM, 64'h8000_0000_0000_0001, 6'd1, 1'b1, 1'b1, 1'b1);
		// forward walk with two real interchanges and two self targets
		tab_add(ROW_ELEM, 64'h0123_4567_89ab_cdef, 6'd2, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'hfedc_ba98_7654_3210, 6'd3, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h5555_aaaa_5555_aaaa, 6'd2, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'haaaa_5555_aaaa_5555, 6'd3, 1'b1, 1'b0, 1'b0);
		// one target past the loaded count flags the whole vector
		tab_add(ROW_ELEM, 64'h1111_1111_1111_1111, 6'd0, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h2222_2222_2222_2222, 6'd7, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h3333_3333_3333_3333, 6'd1, 1'b1, 1'b0, 1'b0);
		// crossed pair: swaps twice, undoes itself
		tab_add(ROW_ELEM, 64'h0f0f_0f0f_0f0f_0f0f, 6'd1, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'hf0f0_f0f0_f0f0_f0f0, 6'd0, 1'b1, 1'b0, 1'b0);
		// reverse walk: first vector and crossed pair again, a single element, a bad target
		tab_add(ROW_CFG,  64'd1, 6'd0, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h0123_4567_89ab_cdef, 6'd2, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'hfedc_ba98_7654_3210, 6'd3, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h5555_aaaa_5555_aaaa, 6'd2, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'haaaa_5555_aaaa_5555, 6'd3, 1'b1, 1'b0, 1'b0);
		tab_add(ROW_ELEM, '1, 6'd0, 1'b1, 1'b1, 1'b0);
		tab_add(ROW_ELEM, 64'h0f0f_0f0f_0f0f_0f0f, 6'd1, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'hf0f0_f0f0_f0f0_f0f0, 6'd0, 1'b1, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h7fff_ffff_ffff_fffe, 6'd63, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h0000_0000_0000_0001, 6'd0, 1'b0, 1'b0, 1'b0);
		tab_add(ROW_ELEM, 64'h8000_0000_0000_0000, 6'd0, 1'b1, 1'b0, 1'b0);

		// reset once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: walk the table, register writes only when idle
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				drain();
				write_cfg(dir_tab[i].cfg_val);
			end else
				offer(dir_tab[i].e, dir_tab[i].pinned, dir_tab[i].pin_bad);
		end
		drain();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			write_cfg(ph[0]);
			goal = elems_sent + PHASE_ITEMS;
			// overlong vector (mark lands on a dropped element) and a full one
			if (ph == 0) begin
				send_vector(MAX_LEN + 2);
				send_vector(MAX_LEN);
			end
			while (elems_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 70)
					len = $urandom_range(8, 1);
				else if (pick < 90)
					len = $urandom_range(24, 9);
				else if (pick < 97)
					len = $urandom_range(MAX_LEN, MAX_LEN - 4);
				else
					len = $urandom_range(MAX_LEN + 6, MAX_LEN + 1);
				send_vector(len);
			end
			drain();
		end

		// pressure: output held off while a full vector and more keep coming
		idle_pct  = 0;
		stall_pct = 0;
		write_cfg(1'($urandom_range(1)));
		hold_req = 1'b1;
		send_vector(MAX_LEN);
		repeat (3) send_vector($urandom_range(8, 3));
		drain();

		$display("ran %0d vectors, %0d elements, %0d results checked, %0d mismatches",
			vectors_done, elems_sent, results_checked, errors);
		$display("both walk directions, bad and self targets, overlong vectors, stalls and a long hold");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
